FILE: rtl/hpb_pkg.sv
`default_nettype none

package hpb_pkg;

    // histogram geometry
    localparam int LEVELS           = 256;
    localparam int LEVEL_W          = $clog2(LEVELS);
    localparam int MAX_FRAME_PIXELS = 4194304;
    localparam int COUNT_W          = 23;
    // running sum over all bins cannot pass LEVELS * MAX_FRAME_PIXELS
    localparam int RUN_W            = COUNT_W + LEVEL_W;

    // pixel and register widths
    localparam int PIXEL_W          = 8;
    localparam int DIV_W            = 8;
    localparam int PROD_W           = RUN_W + DIV_W;
    localparam logic [DIV_W-1:0]   DIV_RESET  = DIV_W'(15);
    localparam logic [PIXEL_W-1:0] PIXEL_HIGH = PIXEL_W'(255);
    localparam logic [PIXEL_W-1:0] PIXEL_LOW  = PIXEL_W'(0);

    // input op codes
    localparam logic OP_COUNT    = 1'b0;
    localparam logic OP_BINARIZE = 1'b1;

    // output kind codes
    localparam logic KIND_LEVEL = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_SEARCH,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic count_word;   // count word accepted
        logic bin_word;     // binarize word accepted
        logic sweep;        // step the bin sweep, zeroing one bin
        logic search;       // sweep also feeds the level search
        logic emit;         // latch level, load it to the output, start a new frame
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
        logic sweep_last;   // sweep sits on the last bin
        logic search_busy;  // search pipeline still holds data
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/histogram_percentile_binarizer.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pixel; tuser: op; tlast: last_pixel
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: threshold_level, pixel_out; tuser: kind
// cfg       in   cfg_we (no ready)             cfg_data: fraction_divisor
//
// count and binarize words are taken one per cycle while the output register drains
// the last count word of a frame starts a sweep of all LEVELS histogram bins through
// the bin memory write and read ports; input stays stalled through the drain, search,
// flush and emit states until the level word is loaded into the output register
// after reset a clearing pass zeroes the bin memory, with no input taken
// a stalled output holds its word and blocks new input words
`default_nettype none

module histogram_percentile_binarizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // count/binarize words
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] pixel
    input  wire logic                          s_axis_tuser,   // [0] op
    input  wire logic                          s_axis_tlast,   // last pixel of frame
    // result words
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [15:0]                   m_axis_tdata,   // [7:0] threshold_level,
                                                               // [15:8] pixel_out
    output logic                               m_axis_tuser,   // [0] kind
    // percentile divisor register
    input  wire logic                          cfg_we,
    input  wire logic [hpb_pkg::DIV_W-1:0]     cfg_data
);

    import hpb_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [PIXEL_W-1:0] out_level;
    logic [PIXEL_W-1:0] out_pixel;

    // sequencing: post-reset clear, frame counting, level search, level emit
    hpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // histogram memory, frame total, search pipeline and output register
    hpb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_pixel  (s_axis_tdata[PIXEL_W-1:0]),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_level (out_level),
        .out_pixel (out_pixel)
    );

    // threshold level low, binarized pixel high
    assign m_axis_tdata = {out_pixel, out_level};

endmodule

`default_nettype wire

FILE: rtl/hpb_ram.sv
`default_nettype none

module hpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/hpb_ctrl.sv
`default_nettype none

module hpb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_op,
    input  wire logic           in_last,
    output logic                in_ready,
    input  wire hpb_pkg::stat_t stat,
    output hpb_pkg::cmd_t       cmd
);

    import hpb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        accept     = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                in_ready = stat.out_free;
                accept   = in_valid && stat.out_free;
                if (accept)
                begin
                    if (in_op == OP_BINARIZE)
                    begin
                        cmd.bin_word = 1'b1;
                    end
                    else
                    begin
                        cmd.count_word = 1'b1;
                        if (in_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // last count word finishes its bin write
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.sweep  = 1'b1;
                cmd.search = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.search_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_ready_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_RUN)
        else $error("input ready outside run state");

    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_COUNT && in_last) |=> state_reg == ST_DRAIN ##1
            state_reg == ST_SEARCH)
        else $error("frame end did not start the search");

    a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == ST_RUN)
        else $error("emit did not return to run");

endmodule

`default_nettype wire

FILE: rtl/hpb_dp.sv
`default_nettype none

module hpb_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hpb_pkg::cmd_t                 cmd,
    output hpb_pkg::stat_t                     stat,
    input  wire logic [hpb_pkg::PIXEL_W-1:0]   in_pixel,
    input  wire logic                          cfg_we,
    input  wire logic [hpb_pkg::DIV_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_kind,
    output logic      [hpb_pkg::PIXEL_W-1:0]   out_level,
    output logic      [hpb_pkg::PIXEL_W-1:0]   out_pixel
);

    import hpb_pkg::*;

    // configuration
    logic [DIV_W-1:0]   div_reg;

    // histogram memory port
    logic               ram_we;
    logic [LEVEL_W-1:0] ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [LEVEL_W-1:0] ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;

    // count pipeline: read issued on accept, update in the following cycle
    logic               cnt_valid_reg;
    logic [LEVEL_W-1:0] cnt_addr_reg;
    logic [LEVEL_W-1:0] cnt_bin;
    logic               wr_valid_reg;
    logic [LEVEL_W-1:0] wr_addr_reg;
    logic [COUNT_W-1:0] wr_data_reg;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;

    // sweep and search pipeline
    logic [LEVEL_W-1:0] sweep_reg;
    logic [LEVEL_W-1:0] sweep_next;
    logic               rd_valid_reg;
    logic [LEVEL_W-1:0] rd_level_reg;
    logic               run_valid_reg;
    logic [LEVEL_W-1:0] run_level_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;
    logic [PROD_W-1:0]  prod;
    logic               hit;
    logic               found_reg;
    logic [LEVEL_W-1:0] found_level_reg;
    logic [PIXEL_W-1:0] held_reg;
    logic [PIXEL_W-1:0] held_next;

    // output register
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [PIXEL_W-1:0] out_level_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_free;

    hpb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (LEVELS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (32'(in_pixel) >= LEVELS)
        begin
            cnt_bin = LEVEL_W'(LEVELS - 1);
        end
        else
        begin
            cnt_bin = LEVEL_W'(in_pixel);
        end
    end

    // forward the previous update when it hit the same bin
    assign cnt_cur = (wr_valid_reg && wr_addr_reg == cnt_addr_reg) ? wr_data_reg : ram_rdata;
    assign cnt_inc = (cnt_cur < COUNT_W'(MAX_FRAME_PIXELS)) ? cnt_cur + COUNT_W'(1) : cnt_cur;

    always_comb
    begin
        if (cmd.sweep)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = '0;
            ram_raddr = sweep_reg;
        end
        else
        begin
            ram_we    = cnt_valid_reg;
            ram_waddr = cnt_addr_reg;
            ram_wdata = cnt_inc;
            ram_raddr = cnt_bin;
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (cmd.emit)
        begin
            total_next = '0;
        end
        else if (cmd.count_word && total_reg < COUNT_W'(MAX_FRAME_PIXELS))
        begin
            total_next = total_reg + COUNT_W'(1);
        end
    end

    assign sweep_next = (sweep_reg == LEVEL_W'(LEVELS - 1)) ? '0 : sweep_reg + LEVEL_W'(1);

    always_comb
    begin
        run_next = run_reg;
        if (cmd.emit)
        begin
            run_next = '0;
        end
        else if (rd_valid_reg)
        begin
            run_next = run_reg + RUN_W'(ram_rdata);
        end
    end

    assign prod = PROD_W'(run_reg) * PROD_W'(div_reg);
    assign hit  = run_valid_reg && (prod >= PROD_W'(total_reg));

    // no level qualifies: top level
    assign held_next = found_reg ? PIXEL_W'(found_level_reg) : PIXEL_W'(LEVELS - 1);

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= DIV_RESET;
            cnt_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            total_reg     <= '0;
            sweep_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            run_valid_reg <= 1'b0;
            run_reg       <= '0;
            found_reg     <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                div_reg <= cfg_data;
            end
            cnt_valid_reg <= cmd.count_word;
            wr_valid_reg  <= cnt_valid_reg && !cmd.sweep;
            total_reg     <= total_next;
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_next;
            end
            rd_valid_reg  <= cmd.sweep && cmd.search;
            run_valid_reg <= rd_valid_reg;
            run_reg       <= run_next;
            if (cmd.emit)
            begin
                found_reg <= 1'b0;
                held_reg  <= held_next;
            end
            else if (hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit || cmd.bin_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_addr_reg  <= cnt_bin;
        wr_addr_reg   <= cnt_addr_reg;
        wr_data_reg   <= cnt_inc;
        rd_level_reg  <= sweep_reg;
        run_level_reg <= rd_level_reg;
        if (hit && !found_reg)
        begin
            found_level_reg <= run_level_reg;
        end
        if (cmd.emit)
        begin
            out_kind_reg  <= KIND_LEVEL;
            out_level_reg <= held_next;
            out_pixel_reg <= PIXEL_LOW;
        end
        else if (cmd.bin_word)
        begin
            out_kind_reg  <= KIND_PIXEL;
            out_level_reg <= held_reg;
            out_pixel_reg <= (in_pixel > held_reg) ? PIXEL_HIGH : PIXEL_LOW;
        end
    end

    assign stat.out_free    = out_free;
    assign stat.sweep_last  = (sweep_reg == LEVEL_W'(LEVELS - 1));
    assign stat.search_busy = rd_valid_reg || run_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_level = out_level_reg;
    assign out_pixel = out_pixel_reg;

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cnt_valid_reg && cmd.sweep))
        else $error("bin update collides with sweep");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !rd_valid_reg && !run_valid_reg)
        else $error("level emitted before search finished");

    a_emit_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && out_kind_reg == KIND_LEVEL && out_level_reg == held_reg)
        else $error("emitted level not presented");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= COUNT_W'(MAX_FRAME_PIXELS))
        else $error("frame total above capacity");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(cmd.emit || cmd.bin_word))
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

FILE: tb/sv/hpb_checker.sv
`default_nettype none

module hpb_checker
    import hpb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,
    input  wire logic               s_axis_tuser,
    input  wire logic               s_axis_tlast,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [15:0]        m_axis_tdata,
    input  wire logic               m_axis_tuser,
    input  wire logic               cfg_we,
    input  wire logic [DIV_W-1:0]   cfg_data,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic               kind;
        logic [PIXEL_W-1:0] level;
        logic [PIXEL_W-1:0] pix;
    } result_word_t;

    logic [COUNT_W-1:0] hist_bins [LEVELS];
    logic [COUNT_W-1:0] pixels_in_frame;
    logic [PIXEL_W-1:0] held_threshold;
    logic [DIV_W-1:0]   divisor;
    result_word_t       due_words [$];
    result_word_t       got_word;
    result_word_t       want_word;
    int                 errors;
    int unsigned        bin_idx;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        errors     = 0;
    end

    // smallest level whose running count times the divisor reaches the frame total
    function automatic logic [PIXEL_W-1:0] percentile_level();
        longint unsigned running;
        running = 0;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            running += hist_bins[lvl];
            if (running * longint'(divisor) >= longint'(pixels_in_frame))
                return PIXEL_W'(lvl);
        end
        return PIXEL_W'(LEVELS - 1);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (hist_bins[i])
                hist_bins[i] = '0;
            pixels_in_frame = '0;
            held_threshold  = '0;
            divisor         = DIV_RESET;
            due_words.delete();
        end
        else
        begin
            if (cfg_we)
                divisor = cfg_data;

            // result word: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_word.kind  = m_axis_tuser;
                got_word.level = m_axis_tdata[7:0];
                got_word.pix   = m_axis_tdata[15:8];
                if (due_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual kind %0d level %0d pixel %0d",
                             $time, got_word.kind, got_word.level, got_word.pix);
                    errors++;
                end
                else
                begin
                    want_word = due_words.pop_front();
                    if (got_word.kind !== want_word.kind)
                    begin
                        $display("%0t: kind mismatch, expected %0d actual %0d",
                                 $time, want_word.kind, got_word.kind);
                        errors++;
                    end
                    if (got_word.level !== want_word.level)
                    begin
                        $display("%0t: threshold_level mismatch, expected %0d actual %0d",
                                 $time, want_word.level, got_word.level);
                        errors++;
                    end
                    if (got_word.pix !== want_word.pix)
                    begin
                        $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                                 $time, want_word.pix, got_word.pix);
                        errors++;
                    end
                end
            end

            // input word: update the histogram or threshold the pixel
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_BINARIZE)
                begin
                    want_word.kind  = KIND_PIXEL;
                    want_word.level = held_threshold;
                    want_word.pix   = (s_axis_tdata > held_threshold) ? PIXEL_HIGH : PIXEL_LOW;
                    due_words.push_back(want_word);
                end
                else
                begin
                    bin_idx = (s_axis_tdata >= LEVELS) ? LEVELS - 1 : s_axis_tdata;
                    if (hist_bins[bin_idx] < MAX_FRAME_PIXELS)
                        hist_bins[bin_idx]++;
                    if (pixels_in_frame < MAX_FRAME_PIXELS)
                        pixels_in_frame++;
                    if (s_axis_tlast)
                    begin
                        held_threshold = percentile_level();
                        foreach (hist_bins[i])
                            hist_bins[i] = '0;
                        pixels_in_frame = '0;
                        want_word.kind  = KIND_LEVEL;
                        want_word.level = held_threshold;
                        want_word.pix   = PIXEL_LOW;
                        due_words.push_back(want_word);
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= due_words.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    import hpb_pkg::*;

    // receiver hold-off used to back the block up into its input
    localparam int LONG_HOLD = 300;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic [7:0]         s_axis_tdata  = '0;
    logic               s_axis_tuser  = OP_COUNT;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tready = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [DIV_W-1:0]   cfg_data      = '0;
    wire logic          s_axis_tready;
    wire logic          m_axis_tvalid;
    wire logic [15:0]   m_axis_tdata;
    wire logic          m_axis_tuser;

    int                 fail_count;
    int                 pending;
    int                 words_sent  = 0;
    bit                 calm        = 1'b0;   // no idling on either side
    int                 hold_reqs   = 0;      // long hold-offs asked by the sender side
    int                 hold_served = 0;

    // clock: period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    histogram_percentile_binarizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] pixel
        .s_axis_tuser  (s_axis_tuser),    // [0] op
        .s_axis_tlast  (s_axis_tlast),    // last pixel of frame
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] threshold_level, [15:8] pixel_out
        .m_axis_tuser  (m_axis_tuser),    // [0] kind
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    hpb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // offer one word from a falling edge and hold it until accepted
    task automatic send_word(input logic op, input logic [7:0] pix, input logic last);
        // random idle burst ahead of the word
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = pix;
        s_axis_tlast  = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // pixel shapes: flat, narrow cluster, two values, constant
    function automatic logic [7:0] pick_pixel(input int shape, input int base, input int alt);
        int v;
        case (shape)
            0: v = $urandom_range(0, 255);
            1: v = base + $urandom_range(0, 12) - 6;
            2: v = ($urandom_range(0, 3) == 0) ? alt : base;
            default: v = base;
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // one frame of count words, the mark on the last one
    task automatic send_frame(input int len);
        int shape;
        int base;
        int alt;
        shape = $urandom_range(0, 3);
        base  = $urandom_range(0, 255);
        alt   = $urandom_range(0, 255);
        for (int k = 0; k < len; k++)
            send_word(OP_COUNT, pick_pixel(shape, base, alt), k == len - 1);
    endtask

    // binarize words, the last mark set at random (the block ignores it)
    task automatic send_binarize_run(input int n);
        for (int k = 0; k < n; k++)
            send_word(OP_BINARIZE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // mostly whole frames and binarize runs, some stray words
    task automatic run_random(input int n_words);
        int stop_at;
        int pick;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 11)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_frame($urandom_range(100, 300));
                else
                    send_frame($urandom_range(1, 40));
            end
            else if (pick < 18)
                send_binarize_run($urandom_range(1, 20));
            else
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
        // close any open frame so a register write never lands mid-frame
        send_word(OP_COUNT, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // let every predicted word drain, then the search latency
    task automatic settle();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LEVELS + 16) @(negedge clk);
    endtask

    task automatic write_divisor(input logic [DIV_W-1:0] value);
        settle();
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // receiver: random stall bursts, a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_served != hold_reqs)
            begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_served++;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: held level still zero after reset
        send_word(OP_BINARIZE, 8'd0, 1'b0);     // equal to level gives 0
        send_word(OP_BINARIZE, 8'd1, 1'b0);     // just above gives 255
        send_word(OP_BINARIZE, 8'd255, 1'b0);
        send_word(OP_BINARIZE, 8'd128, 1'b1);   // last mark on binarize is ignored
        // frame at the reset divisor
        send_word(OP_COUNT, 8'd200, 1'b0);      // count without mark gives nothing
        send_word(OP_COUNT, 8'd255, 1'b0);
        send_word(OP_COUNT, 8'd0, 1'b0);
        send_word(OP_COUNT, 8'd10, 1'b1);
        send_word(OP_BINARIZE, 8'd0, 1'b0);
        send_word(OP_BINARIZE, 8'd1, 1'b0);
        send_word(OP_BINARIZE, 8'd255, 1'b1);
        // single-pixel frames at both extremes
        send_word(OP_COUNT, 8'd255, 1'b1);
        send_word(OP_BINARIZE, 8'd255, 1'b0);   // top level: nothing is above
        send_word(OP_BINARIZE, 8'd254, 1'b0);
        send_word(OP_COUNT, 8'd0, 1'b1);
        send_word(OP_BINARIZE, 8'd0, 1'b0);
        send_word(OP_BINARIZE, 8'd170, 1'b0);
        send_word(OP_BINARIZE, 8'd85, 1'b1);

        // divisor 1: level reaches the whole frame
        write_divisor(8'd1);
        send_frame(5);
        send_binarize_run(4);
        run_random(180);

        // long receiver hold-off with input still offered, block must back up
        hold_reqs++;
        send_binarize_run(40);
        send_frame(12);
        send_binarize_run(10);

        // largest divisor
        write_divisor(8'd255);
        run_random(190);

        // zero divisor: no level qualifies
        write_divisor(8'd0);
        send_frame(3);
        send_binarize_run(3);
        run_random(120);

        for (int p = 0; p < 3; p++)
        begin
            write_divisor(8'($urandom_range(1, 254)));
            run_random(190);
        end

        write_divisor(8'd2);
        run_random(190);

        // last part: no idling on either side
        write_divisor(DIV_RESET);
        calm = 1'b1;
        run_random(190);

        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LEVELS + 40) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/hpb_pkg.sv
rtl/hpb_ram.sv
rtl/hpb_ctrl.sv
rtl/hpb_dp.sv
rtl/histogram_percentile_binarizer.sv
tb/sv/hpb_checker.sv
tb/sv/tb_top.sv
